// ===== rtl/core/accel_tilt_pitch_roll_defines.svh =====
// assertion macros for the tilt angle block
// used by the files that carry concurrent checks; needs no other file
`ifndef ACCEL_TILT_PITCH_ROLL_DEFINES_SVH
`define ACCEL_TILT_PITCH_ROLL_DEFINES_SVH
`ifndef SYNTHESIS
// check sampled at the rising clock edge, masked while reset is low
`define ATP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("atp check failed");
// implication check with the same clock and reset masking
`define ATP_ASSERT_IMP(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("atp implication check failed");
`else
`define ATP_ASSERT(lbl, clk, rstn, prop)
`define ATP_ASSERT_IMP(lbl, clk, rstn, cond, prop)
`endif
`endif

// ===== rtl/core/atp_pkg.sv =====
// shared types, constants and cos/sin tables of the tilt angle block
// depends on nothing; used by every other file of the block but the macro header
package atp_pkg;

    localparam int FRAC      = 58;
    localparam int NTERMS    = 40;
    localparam int KPITCH    = 90;
    localparam int KROLL     = 180;
    localparam int NUM_CELLS = 8;

    typedef logic signed [15:0] atp_accel_t;
    typedef logic signed [7:0]  atp_pitch_t;
    typedef logic signed [8:0]  atp_roll_t;

    typedef logic [63:0] atp_rtab_t [0:KROLL];
    typedef logic [63:0] atp_ptab_t [0:KPITCH];

    // data handed from one search cell to the next
    typedef struct packed {
        logic [15:0] ay;
        logic [15:0] az;
        logic        zneg;
        logic        yneg;
        logic        yzero;
        logic [31:0] x2;
        logic [31:0] s2;
        logic        xneg;
        logic        xzero;
        logic [NUM_CELLS-1:0] mask;
        logic [7:0]  roll_k;
        logic [6:0]  pitch_k;
    } atp_stage_t;

    localparam logic [NUM_CELLS-1:0] MASK_INIT = NUM_CELLS'(1) << (NUM_CELLS - 1);

    // q58 product of two non-negative q58 values, truncated
    function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[121:58];
    endfunction

    // unit angle 3.1415/180 rad in q58, by long division
    function automatic logic [63:0] unit_q();
        logic [63:0] rem;
        logic [63:0] u;
        rem = 64'd31415;
        u   = 64'd0;
        for (int i = 0; i < FRAC; i++)
        begin
            rem = rem << 1;
            u   = u << 1;
            if (rem >= 64'd1800000)
            begin
                rem = rem - 64'd1800000;
                u   = u | 64'd1;
            end
        end
        return u;
    endfunction

    // taylor series of cos or sin of k units, two's complement q58
    function automatic logic [63:0] series(input int k, input logic want_sin);
        logic [63:0] t;
        logic [63:0] mag;
        logic [63:0] s;
        logic [63:0] c;
        t   = 64'(k) * unit_q();
        mag = t;
        s   = t;
        c   = 64'd1 << FRAC;
        for (int n = 2; n <= NTERMS; n++)
        begin
            mag = mul_q(mag, t) / 64'(n);
            if ((n % 2) == 0)
                c = ((n % 4) == 0) ? c + mag : c - mag;
            else
                s = ((n % 4) == 1) ? s + mag : s - mag;
        end
        return want_sin ? s : c;
    endfunction

    function automatic atp_rtab_t build_rtab(input logic want_sin);
        atp_rtab_t t;
        for (int k = 0; k <= KROLL; k++)
            t[k] = series(k, want_sin);
        return t;
    endfunction

    function automatic atp_ptab_t build_ptab(input logic want_sin);
        atp_ptab_t t;
        logic [63:0] v;
        for (int k = 0; k <= KPITCH; k++)
        begin
            v    = series(k, want_sin);
            t[k] = mul_q(v, v);
        end
        return t;
    endfunction

    localparam atp_rtab_t TAB_COS  = build_rtab(1'b0);
    localparam atp_rtab_t TAB_SIN  = build_rtab(1'b1);
    localparam atp_ptab_t TAB_COS2 = build_ptab(1'b0);
    localparam atp_ptab_t TAB_SIN2 = build_ptab(1'b1);

endpackage

// ===== rtl/core/atp_sample_if.sv =====
// sample channel: valid/ready with one three-axis acceleration sample
// depends on atp_pkg
interface atp_sample_if;
    import atp_pkg::*;

    logic       valid;
    logic       ready;
    atp_accel_t accel_x;
    atp_accel_t accel_y;
    atp_accel_t accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

// ===== rtl/core/atp_angle_if.sv =====
// angle channel: valid/ready with pitch and roll in whole degrees
// depends on atp_pkg
interface atp_angle_if;
    import atp_pkg::*;

    logic       valid;
    logic       ready;
    atp_pitch_t pitch_deg;
    atp_roll_t  roll_deg;

    modport source (output valid, output pitch_deg, output roll_deg, input ready);
    modport sink   (input valid, input pitch_deg, input roll_deg, output ready);
endinterface

// ===== rtl/core/atp_prep.sv =====
// front stage: magnitudes, signs and squares of one sample
// depends on atp_pkg
module atp_prep
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  atp_pkg::atp_accel_t accel_x,
    input  atp_pkg::atp_accel_t accel_y,
    input  atp_pkg::atp_accel_t accel_z,
    output logic                out_valid,
    output atp_pkg::atp_stage_t out_data
);
    import atp_pkg::*;

    logic        valid_reg;
    atp_stage_t  data_reg;
    atp_stage_t  data_next;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [31:0] y2;
    logic [31:0] z2;

    // absolute values and squared magnitudes
    always_comb
    begin
        ax = accel_x[15] ? (~accel_x + 16'd1) : accel_x;
        ay = accel_y[15] ? (~accel_y + 16'd1) : accel_y;
        az = accel_z[15] ? (~accel_z + 16'd1) : accel_z;
        y2 = {16'b0, ay} * {16'b0, ay};
        z2 = {16'b0, az} * {16'b0, az};
        data_next.ay      = ay;
        data_next.az      = az;
        data_next.zneg    = accel_z[15];
        data_next.yneg    = accel_y[15];
        data_next.yzero   = (accel_y == '0);
        data_next.x2      = {16'b0, ax} * {16'b0, ax};
        data_next.s2      = y2 + z2;
        data_next.xneg    = accel_x[15];
        data_next.xzero   = (accel_x == '0);
        data_next.mask    = MASK_INIT;
        data_next.roll_k  = '0;
        data_next.pitch_k = '0;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ===== rtl/core/atp_cell.sv =====
// one search cell: tests one bit of pitch and roll against the tables
// two register stages: split products, then compare and update; depends on atp_pkg
module atp_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  atp_pkg::atp_stage_t in_data,
    output logic                out_valid,
    output atp_pkg::atp_stage_t out_data
);
    import atp_pkg::*;

    // candidate angles and table reads
    logic [7:0]  cand_r;
    logic [7:0]  cand_p;
    logic        r_in_range;
    logic        p_in_range;
    logic [7:0]  r_idx;
    logic [6:0]  p_idx;
    logic [63:0] cos_raw;
    logic [63:0] cos_abs;
    logic [58:0] cos_mag;
    logic [58:0] sin_mag;
    logic [58:0] cos2_mag;
    logic [58:0] sin2_mag;

    // first stage registers
    logic        s1_valid_reg;
    atp_stage_t  s1_data_reg;
    logic        s1_cneg_reg;
    logic        s1_rok_reg;
    logic        s1_pok_reg;
    logic [45:0] ra_lo_reg;
    logic [44:0] ra_hi_reg;
    logic [45:0] rb_lo_reg;
    logic [44:0] rb_hi_reg;
    logic [61:0] pa_lo_reg;
    logic [60:0] pa_hi_reg;
    logic [61:0] pb_lo_reg;
    logic [60:0] pb_hi_reg;

    // second stage
    logic [74:0] ra;
    logic [74:0] rb;
    logic [90:0] pa;
    logic [90:0] pb;
    logic        roll_ok;
    logic        pitch_ok;
    logic        valid_reg;
    atp_stage_t  data_reg;
    atp_stage_t  data_next;

    // candidate selection and table lookup
    always_comb
    begin
        cand_r     = in_data.roll_k | 8'(in_data.mask);
        cand_p     = {1'b0, in_data.pitch_k} | 8'(in_data.mask);
        r_in_range = (cand_r <= 8'(KROLL));
        p_in_range = (cand_p <= 8'(KPITCH));
        r_idx      = r_in_range ? cand_r : 8'd0;
        p_idx      = p_in_range ? cand_p[6:0] : 7'd0;
        cos_raw    = TAB_COS[r_idx];
        cos_abs    = cos_raw[63] ? (~cos_raw + 64'd1) : cos_raw;
        cos_mag    = cos_abs[58:0];
        sin_mag    = TAB_SIN[r_idx][58:0];
        cos2_mag   = TAB_COS2[p_idx][58:0];
        sin2_mag   = TAB_SIN2[p_idx][58:0];
    end

    // first stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    // split partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_data_reg <= in_data;
            s1_cneg_reg <= cos_raw[63];
            s1_rok_reg  <= r_in_range;
            s1_pok_reg  <= p_in_range;
            ra_lo_reg   <= {30'b0, in_data.ay} * {16'b0, cos_mag[29:0]};
            ra_hi_reg   <= {29'b0, in_data.ay} * {16'b0, cos_mag[58:30]};
            rb_lo_reg   <= {30'b0, in_data.az} * {16'b0, sin_mag[29:0]};
            rb_hi_reg   <= {29'b0, in_data.az} * {16'b0, sin_mag[58:30]};
            pa_lo_reg   <= {30'b0, in_data.x2} * {32'b0, cos2_mag[29:0]};
            pa_hi_reg   <= {29'b0, in_data.x2} * {32'b0, cos2_mag[58:30]};
            pb_lo_reg   <= {30'b0, in_data.s2} * {32'b0, sin2_mag[29:0]};
            pb_hi_reg   <= {29'b0, in_data.s2} * {32'b0, sin2_mag[58:30]};
        end
    end

    // combine products, compare and keep the bit when the angle reaches it
    always_comb
    begin
        ra = {29'b0, ra_lo_reg} + {ra_hi_reg, 30'b0};
        rb = {29'b0, rb_lo_reg} + {rb_hi_reg, 30'b0};
        pa = {29'b0, pa_lo_reg} + {pa_hi_reg, 30'b0};
        pb = {29'b0, pb_lo_reg} + {pb_hi_reg, 30'b0};
        priority if (!s1_rok_reg)
            roll_ok = 1'b0;
        else if (!s1_cneg_reg && s1_data_reg.zneg)
            roll_ok = 1'b1;
        else if (s1_cneg_reg && !s1_data_reg.zneg)
            roll_ok = 1'b0;
        else if (!s1_cneg_reg)
            roll_ok = (ra >= rb);
        else
            roll_ok = (ra <= rb);
        pitch_ok  = s1_pok_reg && (pa >= pb);
        data_next = s1_data_reg;
        data_next.mask = s1_data_reg.mask >> 1;
        if (roll_ok)
            data_next.roll_k = s1_data_reg.roll_k | 8'(s1_data_reg.mask);
        if (pitch_ok)
            data_next.pitch_k = s1_data_reg.pitch_k | 7'(s1_data_reg.mask);
    end

    // second stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= s1_valid_reg;
    end

    // second stage payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ===== rtl/core/accel_tilt_pitch_roll.sv =====
// path from sample transfer to angle valid: front stage, 8 search cells of two
// stages each, output register; throughput one sample per cycle,
// set by the fully pipelined row of search cells, one result bit per cell
// the whole pipeline holds while a finished result waits on the output
// reset (rst_n low, asynchronous) clears all valid bits; no other state
module accel_tilt_pitch_roll
(
    input  logic          clk,
    input  logic          rst_n,
    atp_sample_if.sink    sample,
    atp_angle_if.source   angle
);
    import atp_pkg::*;
    `include "accel_tilt_pitch_roll_defines.svh"

    logic       en;
    logic       prep_valid;
    atp_stage_t prep_data;
    logic       cell_valid [0:NUM_CELLS];
    atp_stage_t cell_data  [0:NUM_CELLS];
    logic       out_valid_reg;
    atp_pitch_t pitch_reg;
    atp_roll_t  roll_reg;
    atp_pitch_t pitch_next;
    atp_roll_t  roll_next;
    atp_stage_t last;

    // pipeline moves whenever the output register is free or being taken
    assign en           = !out_valid_reg || angle.ready;
    assign sample.ready = en;

    atp_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample.valid),
        .accel_x   (sample.accel_x),
        .accel_y   (sample.accel_y),
        .accel_z   (sample.accel_z),
        .out_valid (prep_valid),
        .out_data  (prep_data)
    );

    assign cell_valid[0] = prep_valid;
    assign cell_data[0]  = prep_data;

    // row of search cells, msb first
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        atp_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cell_valid[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    // signs and special cases
    always_comb
    begin
        last = cell_data[NUM_CELLS];
        if (last.xzero)
            pitch_next = '0;
        else if (last.xneg)
            pitch_next = atp_pitch_t'(~{1'b0, last.pitch_k} + 8'd1);
        else
            pitch_next = atp_pitch_t'({1'b0, last.pitch_k});
        if (last.yzero)
            roll_next = last.zneg ? atp_roll_t'(KROLL) : '0;
        else if (last.yneg)
            roll_next = atp_roll_t'(~{1'b0, last.roll_k} + 9'd1);
        else
            roll_next = atp_roll_t'({1'b0, last.roll_k});
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= cell_valid[NUM_CELLS];
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
        end
    end

    assign angle.valid     = out_valid_reg;
    assign angle.pitch_deg = pitch_reg;
    assign angle.roll_deg  = roll_reg;

    // checks
    `ATP_ASSERT_IMP(a_pitch_range, clk, rst_n, out_valid_reg,
                    (pitch_reg <= 8'sd90) && (pitch_reg >= -8'sd90))
    `ATP_ASSERT_IMP(a_roll_range, clk, rst_n, out_valid_reg,
                    (roll_reg <= 9'sd180) && (roll_reg >= -9'sd180))
    `ATP_ASSERT(a_accept_enters, clk, rst_n, (sample.valid && sample.ready) |=> prep_valid)
    `ATP_ASSERT_IMP(a_search_done, clk, rst_n, cell_valid[NUM_CELLS],
                    cell_data[NUM_CELLS].mask == '0)
endmodule
